FILE: hw/rtl/lcfs_pkg.sv
// Package for the LED chain fade sequencer: sizes, register indexes, types.
// Used by every module under hw/rtl; depends on nothing.
package lcfs_pkg;

   localparam int NUM_LIGHTS = 6;
   localparam int PWM_STEPS  = 64;
   localparam int LIGHT_W    = 3;
   localparam int DUTY_W     = 6;
   localparam int TIME_W     = 32;
   localparam int DIV_W      = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_FADE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OVERLAP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RETRY    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR    = 3'd5;

   localparam logic [7:0]  FULL_LEVEL = 8'd255;

   typedef struct packed {
      logic [11:0] fade;
      logic [11:0] hold;
      logic [11:0] overlap;
      logic [11:0] cooldown;
      logic [7:0]  retry;
      logic [7:0]  dark_floor;
   } cfg_type;

   typedef struct packed {
      logic            start;
      logic [DIV_W-1:0] dividend;
      logic [11:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [7:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/led_chain_fade_sequencer.sv
// Top level of the LED chain fade sequencer: registers, light state, sequencer.
// Depends on lcfs_pkg and lcfs_divider.

// One req item (a millisecond tick) yields NUM_LIGHTS rsp items, one per light in
// index order, with tlast on the final one. Each light is visited in turn; a light
// in a ramp uses the shared divider, others do not.
// After the lights, the start search visits at most NUM_LIGHTS lights, one a cycle.
// The block then streams its results and accepts the next item once they are
// all taken. Configuration writes go through csr_ only while the block is idle,
// and a pending write is taken before a waiting req item.
module led_chain_fade_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // now_ms [31:0]
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // light_index [2:0], duty [8:3], zero [15:9]
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);
   localparam int N  = lcfs_pkg::NUM_LIGHTS;
   localparam int LW = lcfs_pkg::LIGHT_W;
   localparam int TW = lcfs_pkg::TIME_W;
   localparam logic [LW-1:0] LAST_LIGHT = LW'(N - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EVAL  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_SCALE = 7'b0001000,
      ST_SRCH  = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_WAIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   lcfs_pkg::cfg_type cfg_ff, cfg_in;

   logic [TW-1:0] start_ff [N];
   logic [TW-1:0] cool_ff  [N];
   logic [N-1:0]  busy_ff, busy_in;
   logic [lcfs_pkg::DUTY_W-1:0] duty_ff [N];
   logic [LW-1:0] next_ff, next_in;
   logic [TW-1:0] nst_ff, nst_in;
   logic [TW-1:0] now_ff;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [7:0]    lvl_ff, lvl_in;

   logic          wr_start, wr_cool, wr_duty, clr_cool;
   logic [TW-1:0] wr_time;
   logic [lcfs_pkg::DUTY_W-1:0] wr_duty_val;
   logic          req_fire;

   lcfs_pkg::div_req_type dreq;
   lcfs_pkg::div_rsp_type drsp;

   lcfs_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [11:0] fade_eff;
   logic [13:0] total;
   logic [TW-1:0] step_t, elapsed, tt, tt2;

   always_comb begin
      fade_eff = (cfg_ff.fade == 12'd0) ? 12'd1 : cfg_ff.fade;
      total    = {1'b0, fade_eff, 1'b0} + {2'b0, cfg_ff.hold};
      step_t   = ({2'b0, cfg_ff.overlap} >= total) ? TW'(1)
                 : TW'(total - {2'b0, cfg_ff.overlap});
      elapsed  = now_ff - start_ff[idx_ff];
      tt       = elapsed - TW'(fade_eff);
      tt2      = tt - TW'(cfg_ff.hold);
   end

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {7'd0, duty_ff[idx_ff], idx_ff};
   assign rsp_tlast  = (idx_ff == LAST_LIGHT);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lcfs_pkg::REG_FADE:     cfg_in.fade     = csr_data;
            lcfs_pkg::REG_HOLD:     cfg_in.hold     = csr_data;
            lcfs_pkg::REG_OVERLAP:  cfg_in.overlap  = csr_data;
            lcfs_pkg::REG_COOLDOWN: cfg_in.cooldown = csr_data;
            lcfs_pkg::REG_RETRY:    cfg_in.retry    = csr_data[7:0];
            lcfs_pkg::REG_FLOOR:    cfg_in.dark_floor = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      next_in  = next_ff;
      nst_in   = nst_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      lvl_in   = lvl_ff;
      wr_start = 1'b0;
      wr_cool  = 1'b0;
      wr_duty  = 1'b0;
      clr_cool = 1'b0;
      wr_time  = now_ff;
      wr_duty_val = '0;
      dreq     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EVAL;
               idx_in   = '0;
               if (req_tuser) begin
                  busy_in  = {{(N-1){1'b0}}, 1'b1};
                  clr_cool = 1'b1;
                  next_in  = LW'(1 % N);
                  nst_in   = req_tdata + step_t;
               end
            end
         end
         ST_EVAL: begin
            wr_duty = 1'b1;
            if (busy_ff[idx_ff] && elapsed >= TW'(total)) begin
               busy_in[idx_ff] = 1'b0;
               wr_cool = 1'b1;
               wr_time = now_ff + TW'(cfg_ff.cooldown);
            end else if (busy_ff[idx_ff]) begin
               if (elapsed < TW'(fade_eff)) begin
                  dreq.start    = 1'b1;
                  dreq.dividend = lcfs_pkg::DIV_W'({elapsed[11:0], 8'd0} - elapsed[11:0]);
                  dreq.divisor  = fade_eff;
                  wr_duty = 1'b0;
                  state_in = ST_DIV;
               end else if (tt < TW'(cfg_ff.hold)) begin
                  lvl_in = lcfs_pkg::FULL_LEVEL;
                  wr_duty = 1'b0;
                  state_in = ST_SCALE;
               end else begin
                  dreq.start    = 1'b1;
                  dreq.dividend = lcfs_pkg::DIV_W'({(fade_eff - tt2[11:0]), 8'd0}
                                                   - (fade_eff - tt2[11:0]));
                  dreq.divisor  = fade_eff;
                  wr_duty = 1'b0;
                  state_in = ST_DIV;
               end
            end
            if (wr_duty) begin
               if (idx_ff == LAST_LIGHT) begin
                  state_in = ST_SRCH;
                  idx_in   = next_ff;
                  cnt_in   = '0;
               end else begin
                  idx_in = idx_ff + LW'(1);
               end
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               lvl_in   = drsp.quotient;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            wr_duty = 1'b1;
            wr_duty_val = (lvl_ff < cfg_ff.dark_floor) ? '0
                          : lcfs_pkg::DUTY_W'((16'(lvl_ff) * 16'(lcfs_pkg::PWM_STEPS)) >> 8);
            if (idx_ff == LAST_LIGHT) begin
               state_in = ST_SRCH;
               idx_in   = next_ff;
               cnt_in   = '0;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = ST_EVAL;
            end
         end
         ST_SRCH: begin
            if (now_ff < nst_ff) begin
               state_in = ST_OUT;
               idx_in   = '0;
            end else if (!busy_ff[idx_ff] && now_ff >= cool_ff[idx_ff]) begin
               busy_in[idx_ff] = 1'b1;
               wr_start = 1'b1;
               wr_duty  = 1'b1;
               wr_duty_val = lcfs_pkg::DUTY_W'(1);
               next_in  = (idx_ff == LAST_LIGHT) ? '0 : idx_ff + LW'(1);
               nst_in   = now_ff + step_t;
               state_in = ST_OUT;
               idx_in   = '0;
            end else if (cnt_ff == LAST_LIGHT) begin
               nst_in   = now_ff + TW'(cfg_ff.retry);
               state_in = ST_OUT;
               idx_in   = '0;
            end else begin
               cnt_in = cnt_ff + LW'(1);
               idx_in = (idx_ff == LAST_LIGHT) ? '0 : idx_ff + LW'(1);
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (idx_ff == LAST_LIGHT) begin
                  state_in = ST_WAIT;
               end else begin
                  idx_in = idx_ff + LW'(1);
               end
            end
         end
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= '0;
         next_ff  <= '0;
         nst_ff   <= '0;
         idx_ff   <= '0;
         cfg_ff   <= '{fade: 12'd300, hold: 12'd300, overlap: 12'd100,
                       cooldown: 12'd80, retry: 8'd10, dark_floor: 8'd6};
         for (int i = 0; i < N; i++) begin
            start_ff[i] <= '0;
            cool_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         next_ff  <= next_in;
         nst_ff   <= nst_in;
         idx_ff   <= idx_in;
         cfg_ff   <= cfg_in;
         if (req_fire) begin
            now_ff <= req_tdata;
         end
         for (int i = 0; i < N; i++) begin
            if (clr_cool) begin
               cool_ff[i] <= '0;
            end else if (wr_cool && idx_ff == LW'(i)) begin
               cool_ff[i] <= wr_time;
            end
            // A restart begins light 0 at the accepted timestamp.
            if (req_fire && req_tuser && i == 0) begin
               start_ff[i] <= req_tdata;
            end else if (wr_start && idx_ff == LW'(i)) begin
               start_ff[i] <= now_ff;
            end
            if (wr_duty && idx_ff == LW'(i)) begin
               duty_ff[i] <= wr_duty_val;
            end
         end
      end
   end
endmodule

FILE: hw/rtl/lcfs_divider.sv
// Shared restoring divider: one quotient bit per cycle, 8-bit quotient.
// Depends on lcfs_pkg.
module lcfs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lcfs_pkg::div_req_type req,
   output lcfs_pkg::div_rsp_type rsp
);
   logic [lcfs_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [11:0] dvs_ff, dvs_in;
   logic [7:0]  quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [lcfs_pkg::DIV_W-1:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (req.start) begin
         rem_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Quotient never exceeds 255, so eight steps from bit 7 down suffice.
         trial = {8'd0, dvs_ff} << (cnt_ff - 4'd1);
         quo_in = {quo_ff[6:0], 1'b0};
         if (rem_ff >= trial) begin
            rem_in    = rem_ff - trial;
            quo_in[0] = 1'b1;
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
